// ===== rtl/core/euler_rotate_vertex_normal_defines.svh =====
// Assertion macros shared by the vertex and normal rotator RTL.
// Define ASSERT_OFF to compile every check away; no other dependencies.
`ifndef EULER_ROTATE_VERTEX_NORMAL_DEFINES_SVH
`define EULER_ROTATE_VERTEX_NORMAL_DEFINES_SVH
`ifndef ASSERT_OFF
`define ERV_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define ERV_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define ERV_ASSERT(lbl, clk, rst, prop, msg)
`define ERV_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

// ===== rtl/core/erv_pkg.sv =====
// Shared constants, register codes and types of the vertex and normal rotator.
// No dependencies.
`timescale 1ns / 1ps
package erv_pkg;
  localparam int COORD_WIDTH_DEF    = 32;
  localparam int COEF_FRAC_BITS_DEF = 14;
  localparam int COEF_WIDTH         = 16;
  localparam int CFG_IDX_WIDTH      = 3;
  localparam int MAG_WIDTH          = 30;
  localparam int NORM_TOP           = MAG_WIDTH - 1;
  localparam int SUMSQ_WIDTH        = 2 * MAG_WIDTH + 2;
  localparam int ROOT_WIDTH         = SUMSQ_WIDTH / 2;
  localparam int UNIT_SHIFT         = 16;
  localparam int QUO_WIDTH          = UNIT_SHIFT + 1;
  localparam int ROT_LATENCY        = 2;
  localparam int PRE_LATENCY        = 6;
  localparam int DIV_LATENCY        = QUO_WIDTH + 2;
  localparam int TOTAL_LATENCY      = 3 * ROT_LATENCY + PRE_LATENCY + ROOT_WIDTH + DIV_LATENCY;

  localparam logic signed [COEF_WIDTH-1:0] COEF_ONE  = 16'sd16384;
  localparam logic signed [COEF_WIDTH-1:0] COEF_ZERO = 16'sd0;

  typedef enum logic [CFG_IDX_WIDTH-1:0] {
    REG_COS_X = 3'd0,
    REG_SIN_X = 3'd1,
    REG_COS_Y = 3'd2,
    REG_SIN_Y = 3'd3,
    REG_COS_Z = 3'd4,
    REG_SIN_Z = 3'd5
  } erv_reg_t;

  typedef struct packed {
    logic norm;
    logic last;
  } erv_tag_t;
endpackage

// ===== rtl/core/erv_rot.sv =====
// One plane rotation: multiply stage, then round, shift and guard clamp.
// Depends on erv_pkg.
`timescale 1ns / 1ps
module erv_rot #(
  parameter int GUARD_WIDTH    = erv_pkg::COORD_WIDTH_DEF + 2,
  parameter int COEF_FRAC_BITS = erv_pkg::COEF_FRAC_BITS_DEF,
  parameter int PASS_WIDTH     = 1
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  input  logic signed [GUARD_WIDTH-1:0]        a,
  input  logic signed [GUARD_WIDTH-1:0]        b,
  input  logic signed [erv_pkg::COEF_WIDTH-1:0] c,
  input  logic signed [erv_pkg::COEF_WIDTH-1:0] s,
  input  logic [PASS_WIDTH-1:0]                in_pass,
  output logic                                 out_valid,
  output logic signed [GUARD_WIDTH-1:0]        out_diff,
  output logic signed [GUARD_WIDTH-1:0]        out_sum,
  output logic [PASS_WIDTH-1:0]                out_pass
);
  import erv_pkg::*;

  localparam int PROD_WIDTH = GUARD_WIDTH + COEF_WIDTH;
  localparam int ACC_WIDTH  = PROD_WIDTH + COEF_FRAC_BITS + 2;
  localparam int SHR_WIDTH  = ACC_WIDTH - COEF_FRAC_BITS;
  localparam logic signed [ACC_WIDTH-1:0] HALF =
    {{(ACC_WIDTH-COEF_FRAC_BITS){1'b0}}, 1'b1, {(COEF_FRAC_BITS-1){1'b0}}};

  logic                         prod_valid;
  logic signed [PROD_WIDTH-1:0] p_ac, p_bs, p_as, p_bc;
  logic [PASS_WIDTH-1:0]        prod_pass;
  logic signed [ACC_WIDTH-1:0]  acc_diff, acc_sum;
  logic signed [SHR_WIDTH-1:0]  shr_diff, shr_sum;

  function automatic logic signed [GUARD_WIDTH-1:0] clamp_guard(
    input logic signed [SHR_WIDTH-1:0] v
  );
    logic [SHR_WIDTH-GUARD_WIDTH:0] top;
    top = v[SHR_WIDTH-1:GUARD_WIDTH-1];
    if (top == '0 || top == '1) begin
      return v[GUARD_WIDTH-1:0];
    end else if (v[SHR_WIDTH-1]) begin
      return {1'b1, {(GUARD_WIDTH-1){1'b0}}};
    end else begin
      return {1'b0, {(GUARD_WIDTH-1){1'b1}}};
    end
  endfunction

  always_comb begin
    acc_diff = ACC_WIDTH'(p_ac) - ACC_WIDTH'(p_bs) + HALF;
    acc_sum  = ACC_WIDTH'(p_as) + ACC_WIDTH'(p_bc) + HALF;
    shr_diff = SHR_WIDTH'(acc_diff >>> COEF_FRAC_BITS);
    shr_sum  = SHR_WIDTH'(acc_sum >>> COEF_FRAC_BITS);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prod_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      prod_valid <= in_valid;
      out_valid  <= prod_valid;
    end
    p_ac      <= a * c;
    p_bs      <= b * s;
    p_as      <= a * s;
    p_bc      <= b * c;
    prod_pass <= in_pass;
    out_diff  <= clamp_guard(shr_diff);
    out_sum   <= clamp_guard(shr_sum);
    out_pass  <= prod_pass;
  end
endmodule

// ===== rtl/core/erv_prenorm.sv =====
// Saturation to the coordinate range, magnitude scaling into a fixed window
// and the sum of squares for the normal path. Depends on erv_pkg.
`timescale 1ns / 1ps
module erv_prenorm #(
  parameter int COORD_WIDTH = erv_pkg::COORD_WIDTH_DEF
) (
  input  logic                                        clk,
  input  logic                                        rst,
  input  logic                                        in_valid,
  input  erv_pkg::erv_tag_t                           in_tag,
  input  logic [2:0][COORD_WIDTH+1:0]                 in_vec,
  output logic                                        out_valid,
  output erv_pkg::erv_tag_t                           out_tag,
  output logic [2:0][COORD_WIDTH-1:0]                 out_vals,
  output logic [2:0]                                  out_neg,
  output logic                                        out_nonzero,
  output logic [2:0][erv_pkg::MAG_WIDTH-1:0]          out_mags,
  output logic [erv_pkg::SUMSQ_WIDTH-1:0]             out_sumsq
);
  import erv_pkg::*;

  localparam int GW     = COORD_WIDTH + 2;
  localparam int NGRP   = (COORD_WIDTH + 7) / 8;
  localparam int PADW   = NGRP * 8;
  localparam int GRP_W  = (NGRP > 1) ? $clog2(NGRP) : 1;
  localparam int LEAD_W = GRP_W + 3;
  localparam int SH_W   = $clog2(PADW + MAG_WIDTH);
  localparam int EXT_W  = PADW + MAG_WIDTH;

  logic [PRE_LATENCY-1:0]       valid_pipe;
  erv_tag_t                     tag_pipe [PRE_LATENCY];
  logic [2:0][COORD_WIDTH-1:0]  val_pipe [PRE_LATENCY];
  logic [2:0]                   neg_pipe [PRE_LATENCY];

  logic [2:0][COORD_WIDTH-1:0]  sat_vals;
  logic [2:0]                   sat_neg;
  logic [2:0][COORD_WIDTH-1:0]  mag1, mag2, mag3;
  logic [COORD_WIDTH-1:0]       orv;
  logic [PADW-1:0]              padded;
  logic [NGRP-1:0]              grp_nz, grp_nz_q;
  logic [2:0]                   grp_pos [NGRP];
  logic [2:0]                   grp_pos_q [NGRP];
  logic [GRP_W-1:0]             top_grp;
  logic [LEAD_W-1:0]            lead;
  logic                         sh_right, sh_right_q;
  logic [SH_W-1:0]              sh_amt, sh_amt_q;
  logic                         nz3, nz4, nz5, nz6;
  logic [EXT_W-1:0]             ext, shd;
  logic [2:0][MAG_WIDTH-1:0]    nm_next, nm4, nm5, nm6;
  logic [2*MAG_WIDTH-1:0]       sq [3];
  logic [SUMSQ_WIDTH-1:0]       sumsq;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      sat_neg[i] = in_vec[i][GW-1];
      if (in_vec[i][GW-1:COORD_WIDTH-1] == '0 || in_vec[i][GW-1:COORD_WIDTH-1] == '1) begin
        sat_vals[i] = in_vec[i][COORD_WIDTH-1:0];
      end else if (sat_neg[i]) begin
        sat_vals[i] = {1'b1, {(COORD_WIDTH-1){1'b0}}};
      end else begin
        sat_vals[i] = {1'b0, {(COORD_WIDTH-1){1'b1}}};
      end
    end
  end

  always_comb begin
    orv    = mag1[0] | mag1[1] | mag1[2];
    padded = PADW'(orv);
    for (int g = 0; g < NGRP; g++) begin
      grp_nz[g]  = |padded[g*8 +: 8];
      grp_pos[g] = '0;
      for (int j = 0; j < 8; j++) begin
        if (padded[g*8+j]) grp_pos[g] = 3'(j);
      end
    end
  end

  always_comb begin
    top_grp = '0;
    for (int g = 0; g < NGRP; g++) begin
      if (grp_nz_q[g]) top_grp = GRP_W'(g);
    end
    lead = {top_grp, grp_pos_q[top_grp]};
    if (int'(lead) >= NORM_TOP) begin
      sh_right = 1'b1;
      sh_amt   = SH_W'(int'(lead) - NORM_TOP);
    end else begin
      sh_right = 1'b0;
      sh_amt   = SH_W'(NORM_TOP - int'(lead));
    end
  end

  always_comb begin
    ext = '0;
    shd = '0;
    for (int i = 0; i < 3; i++) begin
      ext        = EXT_W'(mag3[i]);
      shd        = sh_right_q ? (ext >> sh_amt_q) : (ext << sh_amt_q);
      nm_next[i] = shd[MAG_WIDTH-1:0];
    end
  end

  assign sumsq = SUMSQ_WIDTH'(sq[0]) + SUMSQ_WIDTH'(sq[1]) + SUMSQ_WIDTH'(sq[2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_pipe <= '0;
    end else begin
      valid_pipe <= {valid_pipe[PRE_LATENCY-2:0], in_valid};
    end
    tag_pipe[0] <= in_tag;
    val_pipe[0] <= sat_vals;
    neg_pipe[0] <= sat_neg;
    for (int k = 1; k < PRE_LATENCY; k++) begin
      tag_pipe[k] <= tag_pipe[k-1];
      val_pipe[k] <= val_pipe[k-1];
      neg_pipe[k] <= neg_pipe[k-1];
    end
    for (int i = 0; i < 3; i++) begin
      mag1[i] <= sat_vals[i][COORD_WIDTH-1] ? (~sat_vals[i] + 1'b1) : sat_vals[i];
      sq[i]   <= nm4[i] * nm4[i];
    end
    mag2       <= mag1;
    grp_nz_q   <= grp_nz;
    grp_pos_q  <= grp_pos;
    mag3       <= mag2;
    sh_right_q <= sh_right;
    sh_amt_q   <= sh_amt;
    nz3        <= |grp_nz_q;
    nz4        <= nz3;
    nz5        <= nz4;
    nz6        <= nz5;
    nm4        <= nm_next;
    nm5        <= nm4;
    nm6        <= nm5;
    out_sumsq  <= sumsq;
  end

  assign out_valid   = valid_pipe[PRE_LATENCY-1];
  assign out_tag     = tag_pipe[PRE_LATENCY-1];
  assign out_vals    = val_pipe[PRE_LATENCY-1];
  assign out_neg     = neg_pipe[PRE_LATENCY-1];
  assign out_nonzero = nz6;
  assign out_mags    = nm6;
endmodule

// ===== rtl/core/erv_isqrt.sv =====
// Pipelined integer square root, one result bit per stage.
// Depends on erv_pkg.
`timescale 1ns / 1ps
module erv_isqrt #(
  parameter int SIDE_WIDTH = 1
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  input  logic [erv_pkg::SUMSQ_WIDTH-1:0]   radicand,
  input  logic [SIDE_WIDTH-1:0]             in_side,
  output logic                              out_valid,
  output logic [erv_pkg::ROOT_WIDTH-1:0]    root,
  output logic [SIDE_WIDTH-1:0]             out_side
);
  import erv_pkg::*;

  localparam int REM_W = ROOT_WIDTH + 3;

  logic [ROOT_WIDTH-1:0]  valid_q;
  logic [REM_W-1:0]       rem_q   [ROOT_WIDTH];
  logic [ROOT_WIDTH-1:0]  root_q  [ROOT_WIDTH];
  logic [SUMSQ_WIDTH-1:0] rad_q   [ROOT_WIDTH];
  logic [SIDE_WIDTH-1:0]  side_q  [ROOT_WIDTH];
  logic [REM_W-1:0]       rem_nx  [ROOT_WIDTH];
  logic [ROOT_WIDTH-1:0]  root_nx [ROOT_WIDTH];
  logic [SUMSQ_WIDTH-1:0] rad_nx  [ROOT_WIDTH];
  logic [REM_W-1:0]       rem_in, rem_sh, trial;
  logic [ROOT_WIDTH-1:0]  root_in;
  logic [SUMSQ_WIDTH-1:0] rad_in;
  logic                   ge;

  always_comb begin
    rem_in  = '0;
    root_in = '0;
    rad_in  = radicand;
    rem_sh  = '0;
    trial   = '0;
    ge      = 1'b0;
    for (int k = 0; k < ROOT_WIDTH; k++) begin
      if (k == 0) begin
        rem_in  = '0;
        root_in = '0;
        rad_in  = radicand;
      end else begin
        rem_in  = rem_q[k-1];
        root_in = root_q[k-1];
        rad_in  = rad_q[k-1];
      end
      rem_sh     = {rem_in[REM_W-3:0], rad_in[SUMSQ_WIDTH-1 -: 2]};
      trial      = REM_W'({root_in, 2'b01});
      ge         = rem_sh >= trial;
      rem_nx[k]  = ge ? (rem_sh - trial) : rem_sh;
      root_nx[k] = {root_in[ROOT_WIDTH-2:0], ge};
      rad_nx[k]  = rad_in << 2;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_q <= '0;
    end else begin
      valid_q <= {valid_q[ROOT_WIDTH-2:0], in_valid};
    end
    side_q[0] <= in_side;
    for (int k = 1; k < ROOT_WIDTH; k++) begin
      side_q[k] <= side_q[k-1];
    end
    for (int k = 0; k < ROOT_WIDTH; k++) begin
      rem_q[k]  <= rem_nx[k];
      root_q[k] <= root_nx[k];
      rad_q[k]  <= rad_nx[k];
    end
  end

  assign out_valid = valid_q[ROOT_WIDTH-1];
  assign root      = root_q[ROOT_WIDTH-1];
  assign out_side  = side_q[ROOT_WIDTH-1];
endmodule

// ===== rtl/core/erv_div.sv =====
// Three pipelined restoring dividers that scale the normal to unit length,
// and the output register that picks the final vector. Depends on erv_pkg.
`timescale 1ns / 1ps
module erv_div #(
  parameter int COORD_WIDTH = erv_pkg::COORD_WIDTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  input  logic [erv_pkg::ROOT_WIDTH-1:0]      divisor,
  input  logic [2:0][erv_pkg::MAG_WIDTH-1:0]  mags,
  input  logic [2:0]                          neg,
  input  logic                                use_norm,
  input  logic                                last,
  input  logic [2:0][COORD_WIDTH-1:0]         vals,
  output logic                                out_valid,
  output logic [2:0][COORD_WIDTH-1:0]         out_vals,
  output logic                                out_last
);
  import erv_pkg::*;

  localparam int NUM_W  = MAG_WIDTH + UNIT_SHIFT + 1;
  localparam int REM_W  = ROOT_WIDTH + 1;
  localparam int NSTAGE = QUO_WIDTH + 1;

  logic [NSTAGE-1:0]                 valid_q;
  logic [ROOT_WIDTH-1:0]             dvs_q  [NSTAGE];
  logic [2:0][REM_W-1:0]             rem_q  [NSTAGE];
  logic [2:0][QUO_WIDTH-1:0]         qw_q   [NSTAGE];
  logic [2:0]                        neg_q  [NSTAGE];
  logic                              use_q  [NSTAGE];
  logic                              last_q [NSTAGE];
  logic [2:0][COORD_WIDTH-1:0]       val_q  [NSTAGE];
  logic [2:0][REM_W-1:0]             rem_nx [NSTAGE];
  logic [2:0][QUO_WIDTH-1:0]         qw_nx  [NSTAGE];
  logic [2:0][NUM_W-1:0]             num;
  logic [REM_W-1:0]                  rem_sh;
  logic                              ge;
  logic signed [QUO_WIDTH+1:0]       qs [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      num[i] = NUM_W'({mags[i], {UNIT_SHIFT{1'b0}}}) + NUM_W'(divisor >> 1);
    end
    rem_nx[0] = '0;
    qw_nx[0]  = '0;
    for (int i = 0; i < 3; i++) begin
      rem_nx[0][i] = REM_W'(num[i][NUM_W-1:QUO_WIDTH]);
      qw_nx[0][i]  = num[i][QUO_WIDTH-1:0];
    end
    rem_sh = '0;
    ge     = 1'b0;
    for (int k = 1; k < NSTAGE; k++) begin
      for (int i = 0; i < 3; i++) begin
        rem_sh       = {rem_q[k-1][i][REM_W-2:0], qw_q[k-1][i][QUO_WIDTH-1]};
        ge           = rem_sh >= REM_W'(dvs_q[k-1]);
        rem_nx[k][i] = ge ? (rem_sh - REM_W'(dvs_q[k-1])) : rem_sh;
        qw_nx[k][i]  = {qw_q[k-1][i][QUO_WIDTH-2:0], ge};
      end
    end
    for (int i = 0; i < 3; i++) begin
      qs[i] = neg_q[NSTAGE-1][i] ? -$signed({2'b00, qw_q[NSTAGE-1][i]})
                                 : $signed({2'b00, qw_q[NSTAGE-1][i]});
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_q   <= '0;
      out_valid <= 1'b0;
    end else begin
      valid_q   <= {valid_q[NSTAGE-2:0], in_valid};
      out_valid <= valid_q[NSTAGE-1];
    end
    dvs_q[0]  <= divisor;
    neg_q[0]  <= neg;
    use_q[0]  <= use_norm;
    last_q[0] <= last;
    val_q[0]  <= vals;
    for (int k = 1; k < NSTAGE; k++) begin
      dvs_q[k]  <= dvs_q[k-1];
      neg_q[k]  <= neg_q[k-1];
      use_q[k]  <= use_q[k-1];
      last_q[k] <= last_q[k-1];
      val_q[k]  <= val_q[k-1];
    end
    for (int k = 0; k < NSTAGE; k++) begin
      rem_q[k] <= rem_nx[k];
      qw_q[k]  <= qw_nx[k];
    end
    for (int i = 0; i < 3; i++) begin
      out_vals[i] <= use_q[NSTAGE-1] ? COORD_WIDTH'(qs[i]) : val_q[NSTAGE-1][i];
    end
    out_last <= last_q[NSTAGE-1];
  end
endmodule

// ===== rtl/core/euler_rotate_vertex_normal.sv =====
// Euler X-Y-Z rotator for vertex positions and normals, with renormalization.
// Depends on erv_pkg, erv_rot, erv_prenorm, erv_isqrt, erv_div and the defines header.
//
// Usage: drive a vector with start high; it is taken at any edge where busy is
// low, and busy is low except during reset, so one vector may enter in every
// cycle. func selects position (0) or normal to renormalize (1); last_item
// travels with the vector to out_last.
// Each result appears for one cycle with done high, in input order. Sustained
// rate is one vector per cycle. A vector passes through three rotation stages,
// the scaling and squaring, the 31-stage square root and the divider.
// The receiver cannot hold results off, so nothing in the pipeline stalls.
// Coefficients are written through cfg_valid/cfg_ready, one register per beat;
// write them only while no vector is in flight. Reset loads the identity
// rotation and drops every vector in flight; no result appears after reset
// until a new vector is taken.
`timescale 1ns / 1ps
`include "euler_rotate_vertex_normal_defines.svh"
module euler_rotate_vertex_normal #(
  parameter int COORD_WIDTH    = erv_pkg::COORD_WIDTH_DEF,
  parameter int COEF_FRAC_BITS = erv_pkg::COEF_FRAC_BITS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 start,
  output logic                                 busy,
  input  logic                                 func,
  input  logic [COORD_WIDTH-1:0]               coord_x,
  input  logic [COORD_WIDTH-1:0]               coord_y,
  input  logic [COORD_WIDTH-1:0]               coord_z,
  input  logic                                 last_item,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [erv_pkg::CFG_IDX_WIDTH-1:0]    cfg_index,
  input  logic [erv_pkg::COEF_WIDTH-1:0]       cfg_data,
  output logic                                 done,
  output logic [COORD_WIDTH-1:0]               out_x,
  output logic [COORD_WIDTH-1:0]               out_y,
  output logic [COORD_WIDTH-1:0]               out_z,
  output logic                                 out_last
);
  import erv_pkg::*;

  localparam int GW         = COORD_WIDTH + 2;
  localparam int TAG_W      = $bits(erv_tag_t);
  localparam int PASS_W     = TAG_W + GW;
  localparam int SIDE_WIDTH = TAG_W + 1 + 3 + 3 * MAG_WIDTH + 3 * COORD_WIDTH;

  logic signed [COEF_WIDTH-1:0] cos_x, sin_x, cos_y, sin_y, cos_z, sin_z;

  logic                  accepted;
  erv_tag_t              in_tag;
  logic signed [GW-1:0]  x_in, y_in, z_in;

  logic                  r1_valid, r2_valid, r3_valid;
  logic signed [GW-1:0]  y1, z1, x2, z2, x3, y3;
  logic [PASS_W-1:0]     r1_pass, r2_pass, r3_pass;
  erv_tag_t              r1_tag, r2_tag, r3_tag;
  logic signed [GW-1:0]  r1_x, r2_y1, r3_z2;

  logic                          pn_valid;
  erv_tag_t                      pn_tag;
  logic [2:0][COORD_WIDTH-1:0]   pn_vals;
  logic [2:0]                    pn_neg;
  logic                          pn_nonzero;
  logic [2:0][MAG_WIDTH-1:0]     pn_mags;
  logic [SUMSQ_WIDTH-1:0]        pn_sumsq;

  logic                          sq_valid;
  logic [ROOT_WIDTH-1:0]         sq_root;
  logic [SIDE_WIDTH-1:0]         sq_side_in, sq_side;
  erv_tag_t                      sq_tag;
  logic                          sq_nonzero;
  logic [2:0]                    sq_neg;
  logic [2:0][MAG_WIDTH-1:0]     sq_mags;
  logic [2:0][COORD_WIDTH-1:0]   sq_vals;
  logic [2:0][COORD_WIDTH-1:0]   res_vals;

  assign busy      = rst;
  assign cfg_ready = ~rst;
  assign accepted  = start & ~busy;
  assign in_tag    = '{norm: func, last: last_item};
  assign x_in      = GW'($signed(coord_x));
  assign y_in      = GW'($signed(coord_y));
  assign z_in      = GW'($signed(coord_z));

  always_ff @(posedge clk) begin
    if (rst) begin
      cos_x <= COEF_ONE;
      sin_x <= COEF_ZERO;
      cos_y <= COEF_ONE;
      sin_y <= COEF_ZERO;
      cos_z <= COEF_ONE;
      sin_z <= COEF_ZERO;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_COS_X: cos_x <= cfg_data;
        REG_SIN_X: sin_x <= cfg_data;
        REG_COS_Y: cos_y <= cfg_data;
        REG_SIN_Y: sin_y <= cfg_data;
        REG_COS_Z: cos_z <= cfg_data;
        REG_SIN_Z: sin_z <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  erv_rot #(.GUARD_WIDTH(GW), .COEF_FRAC_BITS(COEF_FRAC_BITS), .PASS_WIDTH(PASS_W)) u_rot_x (
    .clk(clk), .rst(rst), .in_valid(accepted), .a(y_in), .b(z_in), .c(cos_x), .s(sin_x),
    .in_pass({in_tag, x_in}), .out_valid(r1_valid), .out_diff(y1), .out_sum(z1),
    .out_pass(r1_pass)
  );
  assign {r1_tag, r1_x} = r1_pass;

  erv_rot #(.GUARD_WIDTH(GW), .COEF_FRAC_BITS(COEF_FRAC_BITS), .PASS_WIDTH(PASS_W)) u_rot_y (
    .clk(clk), .rst(rst), .in_valid(r1_valid), .a(z1), .b(r1_x), .c(cos_y), .s(sin_y),
    .in_pass({r1_tag, y1}), .out_valid(r2_valid), .out_diff(z2), .out_sum(x2),
    .out_pass(r2_pass)
  );
  assign {r2_tag, r2_y1} = r2_pass;

  erv_rot #(.GUARD_WIDTH(GW), .COEF_FRAC_BITS(COEF_FRAC_BITS), .PASS_WIDTH(PASS_W)) u_rot_z (
    .clk(clk), .rst(rst), .in_valid(r2_valid), .a(x2), .b(r2_y1), .c(cos_z), .s(sin_z),
    .in_pass({r2_tag, z2}), .out_valid(r3_valid), .out_diff(x3), .out_sum(y3),
    .out_pass(r3_pass)
  );
  assign {r3_tag, r3_z2} = r3_pass;

  erv_prenorm #(.COORD_WIDTH(COORD_WIDTH)) u_prenorm (
    .clk(clk), .rst(rst), .in_valid(r3_valid), .in_tag(r3_tag),
    .in_vec({r3_z2, y3, x3}), .out_valid(pn_valid), .out_tag(pn_tag),
    .out_vals(pn_vals), .out_neg(pn_neg), .out_nonzero(pn_nonzero),
    .out_mags(pn_mags), .out_sumsq(pn_sumsq)
  );

  assign sq_side_in = {pn_tag, pn_nonzero, pn_neg, pn_mags, pn_vals};

  erv_isqrt #(.SIDE_WIDTH(SIDE_WIDTH)) u_isqrt (
    .clk(clk), .rst(rst), .in_valid(pn_valid), .radicand(pn_sumsq),
    .in_side(sq_side_in), .out_valid(sq_valid), .root(sq_root), .out_side(sq_side)
  );
  assign {sq_tag, sq_nonzero, sq_neg, sq_mags, sq_vals} = sq_side;

  erv_div #(.COORD_WIDTH(COORD_WIDTH)) u_div (
    .clk(clk), .rst(rst), .in_valid(sq_valid), .divisor(sq_root), .mags(sq_mags),
    .neg(sq_neg), .use_norm(sq_tag.norm & sq_nonzero), .last(sq_tag.last),
    .vals(sq_vals), .out_valid(done), .out_vals(res_vals), .out_last(out_last)
  );

  assign out_x = res_vals[0];
  assign out_y = res_vals[1];
  assign out_z = res_vals[2];

  `ERV_ASSERT(a_latency, clk, rst, (start && !busy |-> ##TOTAL_LATENCY done), "vector dropped in pipeline")
  `ERV_ASSERT(a_source, clk, rst, (done |-> $past(start && !busy, TOTAL_LATENCY)), "result without vector")
  `ERV_ASSERT_ALWAYS(a_reset, clk, (rst |=> !done), "result right after reset")
  `ERV_ASSERT_ALWAYS(a_cfg, clk, (cfg_valid && cfg_ready && cfg_index == REG_SIN_X |=> sin_x == $past(cfg_data)), "coefficient write lost")
endmodule
